>>> rtl/cgr_pkg.sv
// Shared constants, types and state codes for the clipped glyph row renderer.
package cgr_pkg;

	// Glyph store geometry and framebuffer pixel size.
	localparam int CHAR_COUNT      = 256;
	localparam int MAX_GLYPH_ROWS  = 16;
	localparam int BYTES_PER_PIXEL = 4;
	localparam int ROW_BYTE_BITS   = 8;

	// Derived widths.
	localparam int ROW_W  = (MAX_GLYPH_ROWS > 1) ? $clog2(MAX_GLYPH_ROWS) : 1;
	localparam int CNT_W  = $clog2(MAX_GLYPH_ROWS + 1);
	localparam int ADDR_W = $clog2(CHAR_COUNT * MAX_GLYPH_ROWS);
	localparam int LC_W   = $clog2(ROW_BYTE_BITS);
	localparam int VW_W   = $clog2(ROW_BYTE_BITS + 1);
	localparam int OFF_W  = 26;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_ROW_PITCH     = 3'd2,
		REG_GLYPH_WIDTH   = 3'd3,
		REG_GLYPH_HEIGHT  = 3'd4
	} cgr_reg_e;

	// Top-level sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLIP,
		ST_ROWS
	} cgr_state_e;

	// Clipping result handed from the clip unit to the row sequencer.
	typedef struct packed {
		logic             empty;
		logic [LC_W-1:0]  lc;
		logic [VW_W-1:0]  vis_w;
		logic [ROW_W-1:0] tc;
		logic [CNT_W-1:0] vis_h;
		logic [OFF_W-1:0] base;
	} cgr_setup_t;

endpackage

>>> rtl/cgr_glyph_mem.sv
// Glyph row store: one write port, one registered read port.
module cgr_glyph_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [cgr_pkg::ADDR_W-1:0] waddr,
	input  logic [7:0]                wdata,
	input  logic                      re,
	input  logic [cgr_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                rdata
);
	import cgr_pkg::*;

	logic [7:0] mem_q [CHAR_COUNT * MAX_GLYPH_ROWS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/cgr_clip.sv
// Clip unit: clips a glyph against the screen and computes the first row offset.
module cgr_clip (
	input  logic signed [12:0] pos_x,
	input  logic signed [12:0] pos_y,
	input  logic [7:0]         char_code,
	input  logic [12:0]        screen_width,
	input  logic [12:0]        screen_height,
	input  logic [14:0]        row_pitch,
	input  logic [3:0]         glyph_width,
	input  logic [4:0]         glyph_height,
	output cgr_pkg::cgr_setup_t setup
);
	import cgr_pkg::*;

	logic [VW_W-1:0]  gw;
	logic [CNT_W-1:0] gh;
	logic [13:0]      lc_w, tc_w;
	logic [11:0]      x0, y0;
	logic [VW_W-1:0]  vw_raw;
	logic [CNT_W-1:0] vh_raw;
	logic [13:0]      x_end, y_end;
	logic [27:0]      prod;
	logic             code_bad;

	// Saturate glyph size.
	assign gw = (int'(glyph_width) > ROW_BYTE_BITS) ? VW_W'(ROW_BYTE_BITS)
		: VW_W'(glyph_width);
	assign gh = (int'(glyph_height) > MAX_GLYPH_ROWS) ? CNT_W'(MAX_GLYPH_ROWS)
		: CNT_W'(glyph_height);

	// Left and top clip amounts and the clamped origin.
	assign lc_w = pos_x[12] ? 14'(-(14'(pos_x))) : 14'd0;
	assign tc_w = pos_y[12] ? 14'(-(14'(pos_y))) : 14'd0;
	assign x0   = pos_x[12] ? 12'd0 : pos_x[11:0];
	assign y0   = pos_y[12] ? 12'd0 : pos_y[11:0];
	assign code_bad = int'(char_code) >= CHAR_COUNT;

	// A glyph clipped away on any edge yields no rows.
	assign setup.empty = code_bad || (lc_w >= 14'(gw)) || (tc_w >= 14'(gh))
		|| (13'(x0) >= screen_width) || (13'(y0) >= screen_height);

	// Visible width and height after right and bottom clipping.
	assign vw_raw = gw - VW_W'(lc_w);
	assign vh_raw = gh - CNT_W'(tc_w);
	assign x_end  = 14'(x0) + 14'(vw_raw);
	assign y_end  = 14'(y0) + 14'(vh_raw);

	always_comb begin
		setup.vis_w = vw_raw;
		if (x_end > 14'(screen_width)) begin
			setup.vis_w = VW_W'(screen_width - 13'(x0));
		end
		setup.vis_h = vh_raw;
		if (y_end > 14'(screen_height)) begin
			setup.vis_h = CNT_W'(screen_height - 13'(y0));
		end
	end

	assign setup.lc = LC_W'(lc_w);
	assign setup.tc = ROW_W'(tc_w);

	// Byte offset of the first visible pixel of the first visible row.
	assign prod       = 28'(y0) * 28'(row_pitch);
	assign setup.base = prod[OFF_W-1:0] + OFF_W'(32'(x0) * BYTES_PER_PIXEL);

endmodule

>>> rtl/cgr_row_seq.sv
// Row sequencer: reads one glyph row per cycle while the output is not stalled, builds its mask and offset.
module cgr_row_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  cgr_pkg::cgr_setup_t        setup,
	input  logic [7:0]                 char_code,
	input  logic [14:0]                row_pitch,
	output logic                       mem_re,
	output logic [cgr_pkg::ADDR_W-1:0] mem_raddr,
	input  logic [7:0]                 mem_rdata,
	output logic                       busy,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [cgr_pkg::OFF_W-1:0]  out_offset,
	output logic [7:0]                 out_mask,
	output logic                       out_last
);
	import cgr_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [ROW_W-1:0] row_q;
	logic [OFF_W-1:0] off_q;
	logic [LC_W-1:0]  lc_q;
	logic [VW_W-1:0]  vw_q;
	logic             v_s1;
	logic [OFF_W-1:0] off_s1;
	logic             last_s1;
	logic             adv;
	logic [7:0]       rev;
	logic [7:0]       mask;

	// Move the read stage into the output register when it is free.
	assign adv    = v_s1 && (!out_valid || out_ready);
	assign mem_re = (cnt_q != '0) && (!v_s1 || adv);
	assign mem_raddr = ADDR_W'(int'(char_code) * MAX_GLYPH_ROWS + int'(row_q));
	assign busy   = (cnt_q != '0) || v_s1 || out_valid;

	// Row counters and the shared offset adder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= setup.vis_h;
		end else if (mem_re) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			row_q <= setup.tc;
			off_q <= setup.base;
			lc_q  <= setup.lc;
			vw_q  <= setup.vis_w;
		end else if (mem_re) begin
			row_q <= row_q + ROW_W'(1);
			off_q <= off_q + OFF_W'(row_pitch);
		end
	end

	// Read stage: the glyph row arrives from the store in the cycle after issue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (mem_re) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			off_s1  <= off_q;
			last_s1 <= (cnt_q == CNT_W'(1));
		end
	end

	// Mask: visible column j takes glyph bit 7 - (left clip + j).
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			rev[i] = mem_rdata[7 - i];
		end
		mask = (rev >> lc_q) & ~(8'hFF << vw_q);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_offset <= off_s1;
			out_mask   <= mask;
			out_last   <= last_s1;
		end
	end

endmodule

>>> rtl/clipped_glyph_row_renderer.sv
// Top level of the clipped glyph row renderer: ports, configuration and control.
// A load transaction writes one glyph row into the 4096-byte store,
// and the next transaction can be taken at the following clock edge.
// A draw transaction is clipped in the clip state, then visible glyph rows are read from
// the store at one row per cycle while the output is not stalled, through its single
// read port, and emitted in order. The next transaction is taken only once every row
// of the draw has left; each row that waits on the output holds it back. A wholly
// clipped draw goes from the clip state straight back to idle, reading nothing.
// The glyph store is not cleared at reset; a draw must only read rows that were
// loaded before.
module clipped_glyph_row_renderer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// pos_x[12:0], pos_y[25:13], char_code[33:26], load_row[37:34],
	// row_bits[45:38], color[77:46], zero[79:78]
	input  logic [79:0] s_tdata,
	// action[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// row_offset[25:0], pixel_mask[33:26], pixel_value[65:34], zero[71:66]
	output logic [71:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data
);
	import cgr_pkg::*;

	cgr_state_e state_q, state_d;

	logic [12:0] screen_width_q, screen_height_q;
	logic [14:0] row_pitch_q;
	logic [3:0]  glyph_width_q;
	logic [4:0]  glyph_height_q;

	logic signed [12:0] pos_x_q, pos_y_q;
	logic [7:0]         code_q;
	logic [31:0]        color_q;

	logic               in_acc;
	logic               load_we;
	logic [ADDR_W-1:0]  load_addr;
	logic               start;
	cgr_setup_t         setup;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_raddr;
	logic [7:0]         mem_rdata;
	logic               busy;
	logic [OFF_W-1:0]   out_offset;
	logic [7:0]         out_mask;

	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= 13'd1024;
			screen_height_q <= 13'd768;
			row_pitch_q     <= 15'd4096;
			glyph_width_q   <= 4'd8;
			glyph_height_q  <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[12:0];
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[12:0];
				REG_ROW_PITCH:     row_pitch_q     <= cfg_data;
				REG_GLYPH_WIDTH:   glyph_width_q   <= cfg_data[3:0];
				REG_GLYPH_HEIGHT:  glyph_height_q  <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// Draw parameters captured at acceptance.
	always_ff @(posedge clk) begin
		if (in_acc && !s_tuser) begin
			pos_x_q <= s_tdata[12:0];
			pos_y_q <= s_tdata[25:13];
			code_q  <= s_tdata[33:26];
			color_q <= s_tdata[77:46];
		end
	end

	// Glyph row loads go straight into the store.
	assign load_we   = in_acc && s_tuser && (int'(s_tdata[37:34]) < MAX_GLYPH_ROWS)
		&& (int'(s_tdata[33:26]) < CHAR_COUNT);
	assign load_addr = ADDR_W'(int'(s_tdata[33:26]) * MAX_GLYPH_ROWS
		+ int'(s_tdata[37:34]));

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		start    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && !s_tuser) begin
					state_d = ST_CLIP;
				end
			end
			ST_CLIP: begin
				if (setup.empty) begin
					state_d = ST_IDLE;
				end else begin
					start   = 1'b1;
					state_d = ST_ROWS;
				end
			end
			ST_ROWS: begin
				if (!busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	cgr_clip u_clip (
		.pos_x         (pos_x_q),
		.pos_y         (pos_y_q),
		.char_code     (code_q),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.row_pitch     (row_pitch_q),
		.glyph_width   (glyph_width_q),
		.glyph_height  (glyph_height_q),
		.setup         (setup)
	);

	cgr_glyph_mem u_mem (
		.clk   (clk),
		.we    (load_we),
		.waddr (load_addr),
		.wdata (s_tdata[45:38]),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	cgr_row_seq u_rows (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.setup      (setup),
		.char_code  (code_q),
		.row_pitch  (row_pitch_q),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.busy       (busy),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_offset (out_offset),
		.out_mask   (out_mask),
		.out_last   (m_tlast)
	);

	assign m_tdata = {6'd0, color_q, out_mask, out_offset};

	// Input is only taken once every row of the previous draw has left.
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid && !busy)
		else $error("input ready while rows are still pending");

	// Nothing follows the final row of a character.
	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid && !busy)
		else $error("row emitted after the last row");

	// The store is only read while a draw is running.
	a_read_in_draw: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> state_q == ST_ROWS)
		else $error("glyph store read outside a draw");

	// A load never coincides with a store read.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		load_we |-> !mem_re && !busy)
		else $error("glyph load during a draw");

endmodule

>>> dv/tb.sv
// Self-checking testbench for the clipped glyph row renderer.
`timescale 1ns / 100ps

module tb;
	import cgr_pkg::*;

	// Action codes carried in s_tuser.
	localparam logic ACT_DRAW = 1'b0;
	localparam logic ACT_LOAD = 1'b1;

	// Register indexes that lie beyond the register list.
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	// Cycles the block may still be busy after its last row write.
	localparam int DRAIN_CYCLES = 32;
	localparam int LONG_HOLD_CYCLES = 300;

	typedef struct {
		logic               action;
		logic signed [12:0] pos_x;
		logic signed [12:0] pos_y;
		logic [7:0]         char_code;
		logic [3:0]         load_row;
		logic [7:0]         row_bits;
		logic [31:0]        color;
	} glyph_item_t;

	typedef struct {
		logic [25:0] offset;
		logic [7:0]  mask;
		logic [31:0] value;
		logic        last;
	} row_write_t;

	typedef struct {
		bit ok;
		int lc;
		int tc;
		int x0;
		int y0;
		int vw;
		int vh;
	} clip_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [14:0] cfg_data = '0;

	// Shadow copy of the configuration registers.
	logic [12:0] width_reg = 13'd1024;
	logic [12:0] height_reg = 13'd768;
	logic [14:0] pitch_reg = 15'd4096;
	logic [3:0]  gwidth_reg = 4'd8;
	logic [4:0]  gheight_reg = 5'd16;

	// Predicted glyph store, and rows that generated loads have written.
	logic [7:0] glyph_mem [CHAR_COUNT*MAX_GLYPH_ROWS];
	bit         row_loaded [CHAR_COUNT*MAX_GLYPH_ROWS];

	glyph_item_t pending_items[$];
	row_write_t  expected_rows[$];
	glyph_item_t cur_item;
	logic [7:0]  char_pool [8] = '{8'h00, 8'h01, 8'h41, 8'h7F, 8'h80, 8'hAA, 8'hFE, 8'hFF};

	bit in_taken = 0;
	bit calm = 0;
	bit long_hold_req = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	int mismatch_count = 0;

	clipped_glyph_row_renderer uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Clip a glyph at the given position against the screen edges.
	function automatic clip_t clip_glyph(logic signed [12:0] px, logic signed [12:0] py);
		int gw = (gwidth_reg > ROW_BYTE_BITS) ? ROW_BYTE_BITS : gwidth_reg;
		int gh = (gheight_reg > MAX_GLYPH_ROWS) ? MAX_GLYPH_ROWS : gheight_reg;
		int x = px;
		int y = py;
		clip_t c;
		c.ok = 0;
		c.lc = (x < 0) ? -x : 0;
		c.tc = (y < 0) ? -y : 0;
		c.x0 = (x < 0) ? 0 : x;
		c.y0 = (y < 0) ? 0 : y;
		c.vw = 0;
		c.vh = 0;
		if (c.lc >= gw || c.tc >= gh)
			return c;
		if (c.x0 >= int'(width_reg) || c.y0 >= int'(height_reg))
			return c;
		c.vw = gw - c.lc;
		if (c.x0 + c.vw > int'(width_reg))
			c.vw = int'(width_reg) - c.x0;
		c.vh = gh - c.tc;
		if (c.y0 + c.vh > int'(height_reg))
			c.vh = int'(height_reg) - c.y0;
		c.ok = 1;
		return c;
	endfunction

	// Work out the row writes that one accepted draw causes.
	function automatic void predict_rows(glyph_item_t it);
		clip_t c = clip_glyph(it.pos_x, it.pos_y);
		row_write_t w;
		logic [7:0] bits;
		longint off;
		if (!c.ok)
			return;
		for (int yy = 0; yy < c.vh; yy++) begin
			bits = glyph_mem[it.char_code * MAX_GLYPH_ROWS + c.tc + yy];
			w.mask = '0;
			for (int xx = 0; xx < c.vw; xx++) begin
				if (bits[ROW_BYTE_BITS - 1 - (c.lc + xx)])
					w.mask[xx] = 1'b1;
			end
			off = longint'(c.y0 + yy) * pitch_reg + longint'(c.x0) * BYTES_PER_PIXEL;
			w.offset = off[25:0];
			w.value = it.color;
			w.last = (yy == c.vh - 1);
			expected_rows.push_back(w);
		end
	endfunction

	function automatic int rand_between(int lo, int hi);
		if (hi <= lo)
			return lo;
		return lo + int'($urandom_range(hi - lo));
	endfunction

	// Pick a coordinate, often close to one of the two clip edges.
	function automatic int pick_coord(int extent, int glen);
		int v;
		case ($urandom_range(0, 4))
			0: v = rand_between(-glen - 2, 2);
			1: v = rand_between(extent - glen - 2, extent + 2);
			2: v = rand_between(-4096, 4095);
			3: v = rand_between(0, (extent > 4096) ? 4095 : extent - 1);
			default: begin
				case ($urandom_range(0, 3))
					0: v = -4096;
					1: v = 4095;
					2: v = -1;
					default: v = 0;
				endcase
			end
		endcase
		if (v < -4096)
			v = -4096;
		if (v > 4095)
			v = 4095;
		return v;
	endfunction

	task automatic queue_load(logic [7:0] code, logic [3:0] row, logic [7:0] bits);
		glyph_item_t it;
		it.action = ACT_LOAD;
		it.pos_x = 13'($urandom);
		it.pos_y = 13'($urandom);
		it.char_code = code;
		it.load_row = row;
		it.row_bits = bits;
		it.color = $urandom;
		row_loaded[code * MAX_GLYPH_ROWS + row] = 1;
		pending_items.push_back(it);
	endtask

	// Queue a draw, loading first any glyph row it reads that was never written.
	task automatic queue_draw(int x, int y, logic [7:0] code, logic [31:0] color);
		glyph_item_t it;
		clip_t c;
		it.action = ACT_DRAW;
		it.pos_x = 13'(x);
		it.pos_y = 13'(y);
		it.char_code = code;
		it.load_row = 4'($urandom);
		it.row_bits = 8'($urandom);
		it.color = color;
		c = clip_glyph(it.pos_x, it.pos_y);
		if (c.ok) begin
			for (int r = c.tc; r < c.tc + c.vh; r++) begin
				if (!row_loaded[code * MAX_GLYPH_ROWS + r])
					queue_load(code, 4'(r), 8'($urandom));
			end
		end
		pending_items.push_back(it);
	endtask

	// Write one configuration register and track it in the shadow copy.
	task automatic write_reg(logic [2:0] idx, logic [14:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SCREEN_WIDTH:  width_reg = val[12:0];
			REG_SCREEN_HEIGHT: height_reg = val[12:0];
			REG_ROW_PITCH:     pitch_reg = val;
			REG_GLYPH_WIDTH:   gwidth_reg = val[3:0];
			REG_GLYPH_HEIGHT:  gheight_reg = val[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every item is taken and every row write has arrived.
	task automatic wait_idle();
		while (pending_items.size() != 0 || s_tvalid || expected_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_random_items(int count);
		logic [7:0] code;
		int gw;
		int gh;
		gw = (gwidth_reg > ROW_BYTE_BITS) ? ROW_BYTE_BITS : gwidth_reg;
		gh = (gheight_reg > MAX_GLYPH_ROWS) ? MAX_GLYPH_ROWS : gheight_reg;
		repeat (count) begin
			if ($urandom_range(0, 99) < 15) begin
				queue_load(8'($urandom), 4'($urandom), 8'($urandom));
			end else begin
				code = ($urandom_range(0, 9) < 9) ? char_pool[$urandom_range(0, 7)] :
					8'($urandom);
				queue_draw(pick_coord(width_reg, gw), pick_coord(height_reg, gh), code,
					$urandom);
			end
		end
	endtask

	task automatic run_phase(logic [14:0] sw, logic [14:0] sh, logic [14:0] pitch,
		logic [14:0] gw, logic [14:0] gh, int count);
		wait_idle();
		write_reg(REG_SCREEN_WIDTH, sw);
		write_reg(REG_SCREEN_HEIGHT, sh);
		write_reg(REG_ROW_PITCH, pitch);
		write_reg(REG_GLYPH_WIDTH, gw);
		write_reg(REG_GLYPH_HEIGHT, gh);
		add_random_items(count);
	endtask

	// Input driver: presents queued items and holds each until its transaction.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			in_taken = 0;
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (!calm && pending_items.size() != 0 && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(0, 3);
				s_tvalid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				cur_item = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= cur_item.action;
				s_tdata <= {2'b00, cur_item.color, cur_item.row_bits, cur_item.load_row,
					cur_item.char_code, cur_item.pos_y, cur_item.pos_x};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output receiver: random bursts of back-pressure and one long hold.
	always @(negedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 0;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			recv_gap = $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Predict on each input transaction, check each output transaction.
	always @(posedge clk) begin
		row_write_t want;
		row_write_t seen;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				in_taken = 1;
				if (cur_item.action == ACT_LOAD)
					glyph_mem[cur_item.char_code * MAX_GLYPH_ROWS + cur_item.load_row] =
						cur_item.row_bits;
				else
					predict_rows(cur_item);
			end
			if (m_tvalid && m_tready) begin
				seen.offset = m_tdata[25:0];
				seen.mask = m_tdata[33:26];
				seen.value = m_tdata[65:34];
				seen.last = m_tlast;
				if (expected_rows.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected row write offset=%h mask=%h value=%h last=%b",
						$time, seen.offset, seen.mask, seen.value, seen.last);
				end else begin
					want = expected_rows.pop_front();
					if (want.offset !== seen.offset || want.mask !== seen.mask ||
						want.value !== seen.value || want.last !== seen.last) begin
						mismatch_count++;
						$display("%0t: row write mismatch, expected offset=%h mask=%h value=%h last=%b, actual offset=%h mask=%h value=%h last=%b",
							$time, want.offset, want.mask, want.value, want.last,
							seen.offset, seen.mask, seen.value, seen.last);
					end
				end
			end
		end
	end

	// Stimulus sequence.
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part with four-row glyphs on the default screen.
		write_reg(REG_GLYPH_HEIGHT, 15'd4);
		queue_load(8'hFF, 4'd0, 8'hFF);
		queue_load(8'hFF, 4'd1, 8'h00);
		queue_load(8'hFF, 4'd2, 8'h81);
		queue_load(8'hFF, 4'd3, 8'h7E);
		queue_draw(0, 0, 8'hFF, 32'hFFFF_FFFF);
		queue_draw(0, 0, 8'h00, 32'h0000_0000);
		queue_draw(-3, -1, 8'hFF, 32'h1234_5678);
		queue_draw(1020, 766, 8'hFF, 32'h8765_4321);
		queue_draw(-7, -3, 8'hFF, 32'hA5A5_5A5A);
		queue_draw(-8, 0, 8'hFF, 32'h1);
		queue_draw(0, -4, 8'hFF, 32'h2);
		queue_draw(1024, 0, 8'hFF, 32'h3);
		queue_draw(0, 768, 8'hFF, 32'h4);
		queue_draw(4095, 4095, 8'hFF, 32'h5);
		queue_draw(-4096, -4096, 8'hFF, 32'h6);

		// Largest legal screen and glyph, with a long receiver hold.
		wait_idle();
		long_hold_req = 1;
		run_phase(15'd4096, 15'd4096, 15'd16384, 15'd8, 15'd16, 25);

		// Smallest legal screen and glyph.
		run_phase(15'd1, 15'd1, 15'd4, 15'd1, 15'd1, 10);

		// Random legal settings, small screens favored for clipping.
		repeat (3) begin
			run_phase($urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 4096),
				$urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 4096),
				$urandom_range(4, 16384), $urandom_range(1, 8), $urandom_range(1, 16), 18);
		end

		// Writes to unused indexes, then oversized glyph with all register bits set.
		wait_idle();
		write_reg(REG_SPARE_LO, 15'($urandom));
		write_reg(REG_SPARE_HI, 15'($urandom));
		run_phase(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'hF, 15'h1F, 12);

		// Empty glyph and empty screen settings.
		run_phase(15'd1024, 15'd768, 15'd4096, 15'd0, 15'd16, 3);
		run_phase(15'd1024, 15'd768, 15'd4096, 15'd8, 15'd0, 3);
		run_phase(15'd0, 15'd768, 15'd4096, 15'd8, 15'd16, 3);
		run_phase(15'd1024, 15'd0, 15'd4096, 15'd8, 15'd16, 3);

		// Final stretch at full rate on both sides.
		wait_idle();
		calm = 1;
		run_phase($urandom_range(8, 256), $urandom_range(8, 256), $urandom_range(4, 16384),
			$urandom_range(1, 8), $urandom_range(1, 16), 20);

		wait_idle();
		if (mismatch_count == 0 && expected_rows.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog for a hung run.
	initial begin
		#(5_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
